/* design/gcwq_pkg.sv */
// Shared constants, codes and scan-order functions for the grid cell window query block.
`timescale 1ns / 1ps
`default_nettype none

package gcwq_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int COORD_W = 16;
  localparam int HEIGHT_W = 16;
  localparam int CELL_W = 17;
  localparam int DIFF_W = 17;
  localparam int SIZE_W = 7;
  localparam int WIN = 3;
  localparam int NPOS = 9;

  localparam logic [3:0] CENTRE_POS = 4'd4;
  localparam logic [3:0] LAST_STEP = 4'd8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_OOB = 1'b1;

  localparam logic REG_MAP_WIDTH = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // The centre is read first so that its height is known for every neighbor.
  function automatic logic [3:0] scan_pos(input logic [3:0] step);
    logic [3:0] pos;
    case (step)
      4'd0: pos = CENTRE_POS;
      4'd1: pos = 4'd0;
      4'd2: pos = 4'd1;
      4'd3: pos = 4'd2;
      4'd4: pos = 4'd3;
      4'd5: pos = 4'd5;
      4'd6: pos = 4'd6;
      4'd7: pos = 4'd7;
      4'd8: pos = 4'd8;
      default: pos = CENTRE_POS;
    endcase
    return pos;
  endfunction

  function automatic logic signed [1:0] pos_dx(input logic [3:0] pos);
    logic signed [1:0] d;
    case (pos)
      4'd0, 4'd3, 4'd6: d = -2'sd1;
      4'd2, 4'd5, 4'd8: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] pos_dy(input logic [3:0] pos);
    logic signed [1:0] d;
    case (pos)
      4'd0, 4'd1, 4'd2: d = -2'sd1;
      4'd6, 4'd7, 4'd8: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/gcwq_ram.sv */
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module gcwq_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* design/gcwq_addr.sv */
// Grid bounds check and cell address for one coordinate pair.
`timescale 1ns / 1ps
`default_nettype none

module gcwq_addr #(
  parameter int MAX_COLS = gcwq_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gcwq_pkg::DEF_MAX_ROWS,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic        [gcwq_pkg::SIZE_W-1:0]  map_width,
  input  wire logic        [gcwq_pkg::SIZE_W-1:0]  map_height,
  input  wire logic signed [gcwq_pkg::COORD_W:0]   cx,
  input  wire logic signed [gcwq_pkg::COORD_W:0]   cy,
  output logic                                     in_grid,
  output logic             [AW-1:0]                addr
);

  logic [gcwq_pkg::COORD_W-1:0] width_ext;
  logic [gcwq_pkg::COORD_W-1:0] height_ext;
  logic [gcwq_pkg::COORD_W-1:0] rows_lim;
  logic [gcwq_pkg::COORD_W-1:0] cols_lim;
  logic [AW-1:0] row_a;
  logic [AW-1:0] col_a;

  always_comb begin
    width_ext = gcwq_pkg::COORD_W'(map_width);
    height_ext = gcwq_pkg::COORD_W'(map_height);
    rows_lim = (height_ext > gcwq_pkg::COORD_W'(MAX_ROWS)) ?
               gcwq_pkg::COORD_W'(MAX_ROWS) : height_ext;
    if (rows_lim == '0) begin
      cols_lim = '0;
    end else if (width_ext > gcwq_pkg::COORD_W'(MAX_COLS)) begin
      cols_lim = gcwq_pkg::COORD_W'(MAX_COLS);
    end else begin
      cols_lim = width_ext;
    end
    in_grid = !cx[gcwq_pkg::COORD_W] && !cy[gcwq_pkg::COORD_W] &&
              (cx[gcwq_pkg::COORD_W-1:0] < cols_lim) &&
              (cy[gcwq_pkg::COORD_W-1:0] < rows_lim);
    row_a = AW'(cy[gcwq_pkg::COORD_W-1:0]);
    col_a = AW'(cx[gcwq_pkg::COORD_W-1:0]);
    addr = in_grid ? AW'(row_a * AW'(MAX_COLS)) + col_a : '0;
  end

endmodule

`default_nettype wire

/* design/grid_cell_window_query.sv */
// Top level of the grid cell window query block: sequencer, cell memory and result register.
//
// Input items arrive on in_valid/in_stall and results leave on out_valid/out_stall;
// a transfer happens at a clock edge with valid high and stall low. Each input item
// gives exactly one result. A write command stores one cell and reports status 1 when
// the position lies outside the configured grid. A query reads the 3x3 window from
// the single-port cell memory, centre first, one cell per cycle, and returns the
// walkable mask and the nine height differences.
// One item is worked on at a time; a new item is taken once the previous result has
// moved into the output register, so the next item is taken while that result waits.
// After reset the memory is cleared one cell per cycle, all MAX_COLS*MAX_ROWS cells
// (4096 with the defaults), and in_stall stays high during the clearing pass.
// map_width and map_height are written through cfg_we/cfg_index/cfg_data and are
// taken at once; they should only change while the block is idle. When the receiver
// stalls, the result is held and the block stops after finishing its current item.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_window_query #(
  parameter int MAX_COLS = gcwq_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gcwq_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic        [gcwq_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  command,
  input  wire logic signed [gcwq_pkg::COORD_W-1:0]   x_pos,
  input  wire logic signed [gcwq_pkg::COORD_W-1:0]   y_pos,
  input  wire logic                                  walkable_in,
  input  wire logic signed [gcwq_pkg::HEIGHT_W-1:0]  height_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       status,
  output logic             [gcwq_pkg::NPOS-1:0]      walk_mask,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_nw,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_n,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_ne,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_w,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_c,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_e,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_sw,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_s,
  output logic signed      [gcwq_pkg::DIFF_W-1:0]    diff_se
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [AW-1:0] clr_addr;
  logic [gcwq_pkg::SIZE_W-1:0] map_width;
  logic [gcwq_pkg::SIZE_W-1:0] map_height;

  logic cmd;
  logic signed [gcwq_pkg::COORD_W-1:0] x_reg;
  logic signed [gcwq_pkg::COORD_W-1:0] y_reg;
  logic walk_reg;
  logic signed [gcwq_pkg::HEIGHT_W-1:0] height_reg;
  logic [3:0] step;

  logic rd_pend;
  logic [3:0] rd_pos;
  logic rd_inside;

  logic wk_status;
  logic [gcwq_pkg::NPOS-1:0] wk_mask;
  logic signed [gcwq_pkg::DIFF_W-1:0] wk_diff [gcwq_pkg::NPOS];
  logic signed [gcwq_pkg::HEIGHT_W-1:0] wk_centre;
  logic signed [gcwq_pkg::DIFF_W-1:0] out_diff [gcwq_pkg::NPOS];

  logic [3:0] cur_pos;
  logic signed [1:0] dx;
  logic signed [1:0] dy;
  logic signed [gcwq_pkg::COORD_W:0] cx;
  logic signed [gcwq_pkg::COORD_W:0] cy;
  logic cur_inside;
  logic [AW-1:0] cur_addr;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [gcwq_pkg::CELL_W-1:0] ram_wdata;
  logic [gcwq_pkg::CELL_W-1:0] ram_rdata;
  logic signed [gcwq_pkg::HEIGHT_W-1:0] rd_height;
  logic signed [gcwq_pkg::DIFF_W-1:0] rd_diff;

  logic in_fire;
  logic publish;

  always_comb begin
    cur_pos = gcwq_pkg::scan_pos(step);
    dx = gcwq_pkg::pos_dx(cur_pos);
    dy = gcwq_pkg::pos_dy(cur_pos);
    cx = {x_reg[gcwq_pkg::COORD_W-1], x_reg} + {{(gcwq_pkg::COORD_W - 1){dx[1]}}, dx};
    cy = {y_reg[gcwq_pkg::COORD_W-1], y_reg} + {{(gcwq_pkg::COORD_W - 1){dy[1]}}, dy};
  end

  gcwq_addr #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_addr (
    .map_width(map_width),
    .map_height(map_height),
    .cx(cx),
    .cy(cy),
    .in_grid(cur_inside),
    .addr(cur_addr)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_addr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = (state == ST_RUN) && (cmd == gcwq_pkg::CMD_WRITE) && cur_inside;
      ram_addr = cur_addr;
      ram_wdata = {walk_reg, height_reg};
    end
  end

  gcwq_ram #(
    .WIDTH(gcwq_pkg::CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .addr(ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign rd_height = ram_rdata[gcwq_pkg::HEIGHT_W-1:0];
  assign rd_diff = {rd_height[gcwq_pkg::HEIGHT_W-1], rd_height} -
                   {wk_centre[gcwq_pkg::HEIGHT_W-1], wk_centre};

  assign in_stall = (state != ST_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign publish = (state == ST_DONE) && !rd_pend && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= '0;
      map_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcwq_pkg::REG_MAP_WIDTH: map_width <= cfg_data;
        gcwq_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
        default: map_width <= map_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      step <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          step <= '0;
          if (in_fire) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd == gcwq_pkg::CMD_WRITE) begin
            state <= ST_DONE;
          end else begin
            rd_pend <= 1'b1;
            step <= step + 4'd1;
            if (step == gcwq_pkg::LAST_STEP) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (publish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd <= command;
      x_reg <= x_pos;
      y_reg <= y_pos;
      walk_reg <= walkable_in;
      height_reg <= height_in;
      wk_status <= gcwq_pkg::STATUS_OK;
      wk_mask <= '0;
      wk_centre <= '0;
      for (int i = 0; i < gcwq_pkg::NPOS; i++) begin
        wk_diff[i] <= '0;
      end
    end else begin
      if ((state == ST_RUN) && (cmd == gcwq_pkg::CMD_WRITE)) begin
        wk_status <= cur_inside ? gcwq_pkg::STATUS_OK : gcwq_pkg::STATUS_OOB;
      end
      if (rd_pend) begin
        if (rd_pos == gcwq_pkg::CENTRE_POS) begin
          wk_centre <= rd_inside ? rd_height : '0;
          wk_mask[rd_pos] <= rd_inside && ram_rdata[gcwq_pkg::CELL_W-1];
        end else if (rd_inside) begin
          wk_diff[rd_pos] <= rd_diff;
          wk_mask[rd_pos] <= ram_rdata[gcwq_pkg::CELL_W-1];
        end
      end
    end
    rd_pos <= cur_pos;
    rd_inside <= cur_inside;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      status <= wk_status;
      walk_mask <= wk_mask;
      for (int i = 0; i < gcwq_pkg::NPOS; i++) begin
        out_diff[i] <= wk_diff[i];
      end
    end
  end

  assign diff_nw = out_diff[0];
  assign diff_n = out_diff[1];
  assign diff_ne = out_diff[2];
  assign diff_w = out_diff[3];
  assign diff_c = out_diff[4];
  assign diff_e = out_diff[5];
  assign diff_sw = out_diff[6];
  assign diff_s = out_diff[7];
  assign diff_se = out_diff[8];

endmodule

`default_nettype wire

/* design/gcwq_checker.sv */
// Port-level assertions for the grid cell window query block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module gcwq_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic                                  status,
  input wire logic        [gcwq_pkg::NPOS-1:0]      walk_mask,
  input wire logic signed [gcwq_pkg::DIFF_W-1:0]    diff_nw,
  input wire logic signed [gcwq_pkg::DIFF_W-1:0]    diff_n,
  input wire logic signed [gcwq_pkg::DIFF_W-1:0]    diff_c,
  input wire logic signed [gcwq_pkg::DIFF_W-1:0]    diff_se
);

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input taken while an item is at work.");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(walk_mask)))
    else $error("Stalled result changed.");

  a_centre_diff_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (diff_c == '0))
    else $error("Centre difference is not zero.");

  a_oob_result_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == gcwq_pkg::STATUS_OOB)) |->
    ((walk_mask == '0) && (diff_nw == '0) && (diff_n == '0) && (diff_se == '0)))
    else $error("Out-of-bounds write result carries window data.");

endmodule

bind grid_cell_window_query gcwq_checker u_gcwq_checker (.*);

`default_nettype wire

/* verif/grid_cell_window_query_chk.sv */
// Checker for the grid cell window query block: mirrors the cell grid and compares every result.
`timescale 1ns / 1ps

module grid_cell_window_query_chk (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic        [gcwq_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 command,
  input  logic signed [gcwq_pkg::COORD_W-1:0]  x_pos,
  input  logic signed [gcwq_pkg::COORD_W-1:0]  y_pos,
  input  logic                                 walkable_in,
  input  logic signed [gcwq_pkg::HEIGHT_W-1:0] height_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 status,
  input  logic        [gcwq_pkg::NPOS-1:0]     walk_mask,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_nw,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_n,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_ne,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_w,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_c,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_e,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_sw,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_s,
  input  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_se,
  output int                                   fail_count,
  output int                                   outstanding
);

  localparam int GRID_COLS = gcwq_pkg::DEF_MAX_COLS;
  localparam int GRID_ROWS = gcwq_pkg::DEF_MAX_ROWS;

  typedef struct packed {
    logic                                             status;
    logic [gcwq_pkg::NPOS-1:0]                        mask;
    logic [gcwq_pkg::NPOS-1:0][gcwq_pkg::DIFF_W-1:0]  diffs;
  } window_result_t;

  logic [gcwq_pkg::CELL_W-1:0] grid_cells [GRID_COLS*GRID_ROWS];
  logic [gcwq_pkg::SIZE_W-1:0] map_w_q;
  logic [gcwq_pkg::SIZE_W-1:0] map_h_q;
  window_result_t    expected_windows [$];
  int                results_checked;
  string             diff_names [gcwq_pkg::NPOS] = '{"diff_nw", "diff_n", "diff_ne", "diff_w",
                                                     "diff_c", "diff_e", "diff_sw", "diff_s",
                                                     "diff_se"};

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d: %s", results_checked, msg);
    fail_count++;
  endtask

  function automatic int used_rows();
    return (int'(map_h_q) > GRID_ROWS) ? GRID_ROWS : int'(map_h_q);
  endfunction

  // An empty row count empties the grid whatever the width says.
  function automatic int used_cols();
    if (used_rows() == 0) return 0;
    return (int'(map_w_q) > GRID_COLS) ? GRID_COLS : int'(map_w_q);
  endfunction

  function automatic bit on_grid(input int cx, input int cy);
    return cx >= 0 && cy >= 0 && cx < used_cols() && cy < used_rows();
  endfunction

  function automatic int cell_height(input logic [gcwq_pkg::CELL_W-1:0] word);
    logic signed [gcwq_pkg::HEIGHT_W-1:0] h;
    h = word[gcwq_pkg::HEIGHT_W-1:0];
    return int'(h);
  endfunction

  function automatic window_result_t predict_window(input logic cmd, input int cx, input int cy,
                                                   input logic walk,
                                                   input logic [gcwq_pkg::HEIGHT_W-1:0] h);
    window_result_t r;
    int centre;
    int nx;
    int ny;
    int d;
    logic [gcwq_pkg::CELL_W-1:0] nb_word;
    r = '0;
    if (cmd == gcwq_pkg::CMD_WRITE) begin
      if (on_grid(cx, cy)) begin
        grid_cells[cy*GRID_COLS + cx] = {walk, h};
      end else begin
        r.status = gcwq_pkg::STATUS_OOB;
      end
      return r;
    end
    centre = on_grid(cx, cy) ? cell_height(grid_cells[cy*GRID_COLS + cx]) : 0;
    for (int pos = 0; pos < gcwq_pkg::NPOS; pos++) begin
      nx = cx + pos % gcwq_pkg::WIN - 1;
      ny = cy + pos / gcwq_pkg::WIN - 1;
      if (on_grid(nx, ny)) begin
        nb_word = grid_cells[ny*GRID_COLS + nx];
        d = cell_height(nb_word) - centre;
        r.mask[pos] = nb_word[gcwq_pkg::CELL_W-1];
        r.diffs[pos] = d[gcwq_pkg::DIFF_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    logic signed [gcwq_pkg::DIFF_W-1:0] got_diffs [gcwq_pkg::NPOS];
    logic signed [gcwq_pkg::DIFF_W-1:0] want_diff;
    if (rst) begin
      foreach (grid_cells[i]) grid_cells[i] = '0;
      map_w_q = '0;
      map_h_q = '0;
      expected_windows.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == gcwq_pkg::REG_MAP_WIDTH) begin
          map_w_q = cfg_data;
        end else begin
          map_h_q = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          report_mismatch("result transfer with no expectation waiting");
        end else begin
          want = expected_windows.pop_front();
          got_diffs = '{diff_nw, diff_n, diff_ne, diff_w, diff_c, diff_e, diff_sw, diff_s,
                        diff_se};
          if (status !== want.status)
            report_mismatch($sformatf("status expected %0d, got %0d", want.status, status));
          if (walk_mask !== want.mask)
            report_mismatch($sformatf("walk_mask expected %b, got %b", want.mask, walk_mask));
          for (int p = 0; p < gcwq_pkg::NPOS; p++) begin
            want_diff = want.diffs[p];
            if (got_diffs[p] !== want_diff)
              report_mismatch($sformatf("%s expected %0d, got %0d", diff_names[p], want_diff,
                                        got_diffs[p]));
          end
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        expected_windows.push_back(predict_window(command, int'(x_pos), int'(y_pos),
                                                  walkable_in, height_in));
      end
    end
    outstanding <= expected_windows.size();
  end

endmodule

/* verif/grid_cell_window_query_tb.sv */
// Testbench top for the grid cell window query block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module grid_cell_window_query_tb;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 100;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic                                 cfg_index = 1'b0;
  logic        [gcwq_pkg::SIZE_W-1:0]   cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 command = 1'b0;
  logic signed [gcwq_pkg::COORD_W-1:0]  x_pos = '0;
  logic signed [gcwq_pkg::COORD_W-1:0]  y_pos = '0;
  logic                                 walkable_in = 1'b0;
  logic signed [gcwq_pkg::HEIGHT_W-1:0] height_in = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 status;
  logic        [gcwq_pkg::NPOS-1:0]     walk_mask;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_nw;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_n;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_ne;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_w;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_c;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_e;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_sw;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_s;
  logic signed [gcwq_pkg::DIFF_W-1:0]   diff_se;
  int                                   fail_count;
  int                                   outstanding;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_req_q = 1'b0;
  int hold_left = 0;

  grid_cell_window_query u_top (.*);

  grid_cell_window_query_chk u_chk (.*);

  always #5 clk = ~clk;

  // The receiver stalls at random while idle_on is set, and holds off for a long stretch when asked.
  always @(posedge clk) begin
    hold_req_q <= hold_req;
    if (hold_req && !hold_req_q) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 37);
    end
  end

  task automatic write_reg(input logic idx, input logic [gcwq_pkg::SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(input logic [gcwq_pkg::SIZE_W-1:0] w,
                          input logic [gcwq_pkg::SIZE_W-1:0] h);
    write_reg(gcwq_pkg::REG_MAP_WIDTH, w);
    write_reg(gcwq_pkg::REG_MAP_HEIGHT, h);
  endtask

  task automatic send_item(input logic cmd, input int xv, input int yv, input logic walk,
                           input int hv);
    while (idle_on && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    x_pos <= 16'(xv);
    y_pos <= 16'(yv);
    walkable_in <= walk;
    height_in <= 16'(hv);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Coordinates mostly fall on or just around the grid in use, sometimes anywhere.
  task automatic send_random(input int cols, input int rows);
    int xv;
    int yv;
    int hv;
    if ($urandom_range(0, 9) == 0) begin
      xv = int'($urandom);
      yv = int'($urandom);
    end else begin
      xv = int'($urandom_range(0, cols + 3)) - 2;
      yv = int'($urandom_range(0, rows + 3)) - 2;
    end
    case ($urandom_range(0, 7))
      0: hv = 32767;
      1: hv = -32768;
      2: hv = int'($urandom_range(0, 20)) - 10;
      default: hv = int'($urandom);
    endcase
    send_item($urandom_range(0, 1) ? gcwq_pkg::CMD_QUERY : gcwq_pkg::CMD_WRITE, xv, yv,
              1'($urandom), hv);
  endtask

  task automatic run_phase(input logic [gcwq_pkg::SIZE_W-1:0] w,
                           input logic [gcwq_pkg::SIZE_W-1:0] h,
                           input bit quiet, input bit squeeze);
    int rows;
    int cols;
    set_size(w, h);
    rows = (int'(h) > gcwq_pkg::DEF_MAX_ROWS) ? gcwq_pkg::DEF_MAX_ROWS : int'(h);
    cols = (rows == 0) ? 0 :
           ((int'(w) > gcwq_pkg::DEF_MAX_COLS) ? gcwq_pkg::DEF_MAX_COLS : int'(w));
    idle_on <= !quiet;
    hold_req <= squeeze;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random(cols, rows);
    in_valid <= 1'b0;
    hold_req <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Oversized width saturates to the full grid.
    set_size(7'd127, 7'd64);
    send_item(gcwq_pkg::CMD_WRITE, 0, 0, 1'b1, 32767);
    send_item(gcwq_pkg::CMD_WRITE, 63, 63, 1'b1, -32768);
    send_item(gcwq_pkg::CMD_WRITE, 63, 0, 1'b0, -1);
    send_item(gcwq_pkg::CMD_WRITE, 1, 1, 1'b1, -32768);
    send_item(gcwq_pkg::CMD_WRITE, 1, 0, 1'b1, 32767);
    send_item(gcwq_pkg::CMD_WRITE, 64, 5, 1'b1, 5);
    send_item(gcwq_pkg::CMD_WRITE, -1, 3, 1'b1, 7);
    send_item(gcwq_pkg::CMD_WRITE, 5, 64, 1'b0, 9);
    send_item(gcwq_pkg::CMD_WRITE, -32768, 32767, 1'b1, -1);
    send_item(gcwq_pkg::CMD_QUERY, 1, 1, 1'b0, 0);
    send_item(gcwq_pkg::CMD_QUERY, 0, 0, 1'b1, -1);
    send_item(gcwq_pkg::CMD_QUERY, 63, 63, 1'b0, 0);
    send_item(gcwq_pkg::CMD_QUERY, 64, 64, 1'b0, 0);
    send_item(gcwq_pkg::CMD_QUERY, -1, -1, 1'b0, 0);
    send_item(gcwq_pkg::CMD_QUERY, 32767, -32768, 1'b1, 32767);
    send_item(gcwq_pkg::CMD_QUERY, 10, 10, 1'b0, 0);
    in_valid <= 1'b0;
    drain();

    // With either size at zero every position is off the grid.
    set_size(7'd0, 7'd64);
    send_item(gcwq_pkg::CMD_WRITE, 0, 0, 1'b1, 100);
    send_item(gcwq_pkg::CMD_QUERY, 1, 1, 1'b0, 0);
    in_valid <= 1'b0;
    drain();
    set_size(7'd64, 7'd0);
    send_item(gcwq_pkg::CMD_WRITE, 63, 63, 1'b1, 100);
    send_item(gcwq_pkg::CMD_QUERY, 0, 0, 1'b0, 0);
    in_valid <= 1'b0;
    drain();

    // A shrunken grid hides cells written earlier without clearing them.
    set_size(7'd3, 7'd2);
    send_item(gcwq_pkg::CMD_QUERY, 2, 1, 1'b0, 0);
    send_item(gcwq_pkg::CMD_QUERY, 3, 2, 1'b0, 0);
    in_valid <= 1'b0;
    drain();

    run_phase(7'd64, 7'd64, 1'b0, 1'b1);
    run_phase(7'd8, 7'd8, 1'b0, 1'b0);
    run_phase(7'd127, 7'd127, 1'b1, 1'b0);
    run_phase(7'd1, 7'd1, 1'b0, 1'b0);
    run_phase(7'd2, 7'd64, 1'b0, 1'b0);
    run_phase(7'd64, 7'd1, 1'b0, 1'b0);
    run_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b0, 1'b0);

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
